@@ rtl/pfc_pkg.sv @@
// Playfair cipher unit: shared types, codes and helper functions.
// Used by pfc_store and playfair_digraph_cipher_unit; no dependencies.
package pfc_pkg;

   localparam int unsigned SQ_SIDE  = 5;
   localparam int unsigned SQ_CELLS = 25;
   localparam int unsigned ALPHA    = 26;

   localparam logic [4:0] IDX_I     = 5'd8;
   localparam logic [4:0] IDX_J     = 5'd9;
   localparam logic [4:0] IDX_X     = 5'd23;
   localparam logic [4:0] IDX_LAST  = 5'd25;
   localparam logic [4:0] CELLS_FULL = 5'd25;
   localparam logic [6:0] ASCII_A   = 7'd65;

   localparam logic [2:0] KIND_CLEAR   = 3'd0;
   localparam logic [2:0] KIND_KEYWORD = 3'd1;
   localparam logic [2:0] KIND_SEAL    = 3'd2;
   localparam logic [2:0] KIND_MESSAGE = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_ENCRYPT_MODE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEAL,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_CALC,
      ST_RD_CB,
      ST_WAIT_A,
      ST_WAIT_B
   } pfc_state_type;

   typedef struct packed {
      logic       clear;
      logic       wr_en;
      logic [4:0] wr_letter;
      logic       place_rd_en;
      logic [4:0] place_rd_addr;
      logic       sq_rd_en;
      logic [4:0] sq_rd_addr;
   } pfc_store_ctl_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] idx;
   } pfc_letter_type;

   // Drop non-letters, raise lower case, fold J onto I.
   function automatic pfc_letter_type pfc_filter(logic [7:0] raw);
      pfc_letter_type res;
      res.valid = (raw[7:6] == 2'b01) && (raw[4:0] >= 5'd1) && (raw[4:0] <= 5'd26);
      res.idx   = raw[4:0] - 5'd1;
      if (res.idx == IDX_J) begin
         res.idx = IDX_I;
      end
      return res;
   endfunction

   function automatic logic [2:0] pfc_add5(logic [2:0] v, logic [2:0] sh);
      logic [3:0] sum;
      sum = {1'b0, v} + {1'b0, sh};
      if (sum >= 4'd5) begin
         sum = sum - 4'd5;
      end
      return sum[2:0];
   endfunction

   // Cell for one letter of a pair: own place and partner place as {row, col}.
   function automatic logic [4:0] pfc_xform(logic [5:0] own, logic [5:0] other,
                                            logic enc);
      logic [2:0] sh;
      logic [2:0] r;
      logic [2:0] c;
      sh = enc ? 3'd1 : 3'd4;
      if (own[5:3] == other[5:3]) begin
         r = own[5:3];
         c = pfc_add5(own[2:0], sh);
      end else if (own[2:0] == other[2:0]) begin
         r = pfc_add5(own[5:3], sh);
         c = own[2:0];
      end else begin
         r = own[5:3];
         c = other[2:0];
      end
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
   endfunction

endpackage

@@ rtl/pfc_store.sv @@
// Key square storage: cell and place memories, used-letter flags, fill counters.
// Depends on pfc_pkg.
module pfc_store (
   input  logic                       clock,
   input  logic                       reset,
   input  pfc_pkg::pfc_store_ctl_type ctl,
   output logic                       full,
   output logic [5:0]                 place_rd,
   output logic [4:0]                 sq_rd
);
   import pfc_pkg::*;

   logic [4:0]  sq_mem [SQ_CELLS];
   logic [5:0]  place_mem [ALPHA];
   logic [25:0] used_ff, used_in;
   logic [4:0]  fill_count_ff, fill_count_in;
   logic [2:0]  fill_row_ff, fill_row_in;
   logic [2:0]  fill_col_ff, fill_col_in;
   logic [5:0]  place_rd_ff;
   logic [4:0]  sq_rd_ff;
   logic        do_write;
   logic [25:0] used_reset;

   assign used_reset = 26'(1) << IDX_J;
   assign full       = (fill_count_ff == CELLS_FULL);
   assign do_write   = ctl.wr_en && !used_ff[ctl.wr_letter] && !full;
   assign place_rd   = place_rd_ff;
   assign sq_rd      = sq_rd_ff;

   always_comb begin
      used_in       = used_ff;
      fill_count_in = fill_count_ff;
      fill_row_in   = fill_row_ff;
      fill_col_in   = fill_col_ff;
      if (ctl.clear) begin
         used_in       = used_reset;
         fill_count_in = '0;
         fill_row_in   = '0;
         fill_col_in   = '0;
      end else if (do_write) begin
         used_in[ctl.wr_letter] = 1'b1;
         fill_count_in = fill_count_ff + 5'd1;
         if (fill_col_ff == 3'd4) begin
            fill_col_in = '0;
            fill_row_in = fill_row_ff + 3'd1;
         end else begin
            fill_col_in = fill_col_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= used_reset;
         fill_count_ff <= '0;
         fill_row_ff   <= '0;
         fill_col_ff   <= '0;
      end else begin
         used_ff       <= used_in;
         fill_count_ff <= fill_count_in;
         fill_row_ff   <= fill_row_in;
         fill_col_ff   <= fill_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && !ctl.clear) begin
         sq_mem[fill_count_ff]     <= ctl.wr_letter;
         place_mem[ctl.wr_letter]  <= {fill_row_ff, fill_col_ff};
      end
      if (ctl.place_rd_en) begin
         place_rd_ff <= place_mem[ctl.place_rd_addr];
      end
      if (ctl.sq_rd_en) begin
         sq_rd_ff <= sq_mem[ctl.sq_rd_addr];
      end
   end

endmodule

@@ rtl/playfair_digraph_cipher_unit.sv @@
// Playfair digraph cipher unit, top level: stream ports, register port, sequencer.
// Depends on pfc_pkg and pfc_store.
// A completing message or end pair raises rsp_tvalid after the LOOK_A, LOOK_B, CALC and RD_CB states.
// No new item is taken while a pair is busy (the transfer, 4 lookup steps through the
// single-port memories and the shared cell transform, 2 result transfers) or a seal runs.
// Every other item leaves the unit idle. Reset: square empty, no letter waiting, encrypt_mode set.
module playfair_digraph_cipher_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] letter
   input  logic [2:0]                       req_tuser,   // [2:0] kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [6:0] out_letter, [7] zero
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import pfc_pkg::*;

   pfc_state_type     state_ff, state_in;
   pfc_store_ctl_type ctl;
   pfc_letter_type    filt;

   logic       encrypt_mode_ff;
   logic       pending_valid_ff, pending_valid_in;
   logic [4:0] pending_letter_ff, pending_letter_in;
   logic [4:0] op_a_ff, op_a_in;
   logic [4:0] op_b_ff, op_b_in;
   logic [4:0] seal_idx_ff, seal_idx_in;
   logic [5:0] place_a_ff, place_a_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_letter_ff, rsp_letter_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       full;
   logic [5:0] place_rd;
   logic [4:0] sq_rd;
   logic [5:0] xf_own;
   logic [5:0] xf_other;
   logic [4:0] xf_cell;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       csr_wr;
   logic [6:0] sq_ascii;

   pfc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .full     (full),
      .place_rd (place_rd),
      .sq_rd    (sq_rd)
   );

   assign filt     = pfc_filter(req_tdata);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign sq_ascii = ASCII_A + {2'b00, sq_rd};

   // Shared cell transform: first letter in CALC, second letter in RD_CB.
   assign xf_own   = (state_ff == ST_RD_CB) ? place_rd : place_a_ff;
   assign xf_other = (state_ff == ST_RD_CB) ? place_a_ff : place_rd;
   assign xf_cell  = pfc_xform(xf_own, xf_other, encrypt_mode_ff);

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ENCRYPT_MODE) ? {31'd0, encrypt_mode_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_letter_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_tuser)
                  KIND_SEAL: state_in = ST_SEAL;
                  KIND_MESSAGE: begin
                     if (full && filt.valid && pending_valid_ff) begin
                        state_in = ST_LOOK_A;
                     end
                  end
                  KIND_END: begin
                     if (full && pending_valid_ff) begin
                        state_in = ST_LOOK_A;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEAL: begin
            if (seal_idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOK_A: state_in = ST_LOOK_B;
         ST_LOOK_B: state_in = ST_CALC;
         ST_CALC:   state_in = ST_RD_CB;
         ST_RD_CB:  state_in = ST_WAIT_A;
         ST_WAIT_A: begin
            if (rsp_xfer) begin
               state_in = ST_WAIT_B;
            end
         end
         ST_WAIT_B: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready        = (state_ff == ST_IDLE);
      ctl               = '0;
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      op_a_in           = op_a_ff;
      op_b_in           = op_b_ff;
      seal_idx_in       = seal_idx_ff;
      place_a_in        = place_a_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_letter_in     = rsp_letter_ff;
      rsp_last_in       = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_tuser)
                  KIND_CLEAR: begin
                     ctl.clear         = 1'b1;
                     pending_valid_in  = 1'b0;
                     pending_letter_in = '0;
                  end
                  KIND_KEYWORD: begin
                     ctl.wr_en     = filt.valid;
                     ctl.wr_letter = filt.idx;
                  end
                  KIND_SEAL: seal_idx_in = '0;
                  KIND_MESSAGE: begin
                     if (full && filt.valid) begin
                        if (!pending_valid_ff) begin
                           pending_valid_in  = 1'b1;
                           pending_letter_in = filt.idx;
                        end else if (filt.idx == pending_letter_ff) begin
                           op_a_in = pending_letter_ff;
                           op_b_in = IDX_X;
                        end else begin
                           op_a_in           = pending_letter_ff;
                           op_b_in           = filt.idx;
                           pending_valid_in  = 1'b0;
                           pending_letter_in = '0;
                        end
                     end
                  end
                  KIND_END: begin
                     if (full && pending_valid_ff) begin
                        op_a_in           = pending_letter_ff;
                        op_b_in           = IDX_X;
                        pending_valid_in  = 1'b0;
                        pending_letter_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEAL: begin
            ctl.wr_en     = 1'b1;
            ctl.wr_letter = seal_idx_ff;
            seal_idx_in   = seal_idx_ff + 5'd1;
         end
         ST_LOOK_A: begin
            ctl.place_rd_en   = 1'b1;
            ctl.place_rd_addr = op_a_ff;
         end
         ST_LOOK_B: begin
            ctl.place_rd_en   = 1'b1;
            ctl.place_rd_addr = op_b_ff;
            place_a_in        = place_rd;
         end
         ST_CALC: begin
            ctl.sq_rd_en   = 1'b1;
            ctl.sq_rd_addr = xf_cell;
         end
         ST_RD_CB: begin
            ctl.sq_rd_en   = 1'b1;
            ctl.sq_rd_addr = xf_cell;
            rsp_valid_in   = 1'b1;
            rsp_letter_in  = sq_ascii;
            rsp_last_in    = 1'b0;
         end
         ST_WAIT_A: begin
            if (rsp_xfer) begin
               rsp_letter_in = sq_ascii;
               rsp_last_in   = 1'b1;
            end
         end
         ST_WAIT_B: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         encrypt_mode_ff   <= 1'b1;
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         seal_idx_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
         seal_idx_ff       <= seal_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_wr && csr_paddr[2] == REG_ENCRYPT_MODE) begin
            encrypt_mode_ff <= csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      place_a_ff    <= place_a_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

@@ tb/playfair_digraph_cipher_unit_tb.sv @@
// Self-checking testbench for playfair_digraph_cipher_unit: directed table, then random sessions.
// Holds its own Playfair square predictor; depends on pfc_pkg and the unit under test.
// Stream handshakes with random idling, a long receiver hold-off, and encrypt_mode phases.
module playfair_digraph_cipher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfc_pkg::*;

   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 90;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } cipher_char_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] letter;
   } stim_item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] letter;
      logic       typed;
      logic [7:0] c0;
      logic [7:0] c1;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] letter
   logic [2:0]  req_tuser;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [6:0] out_letter, [7] zero
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   playfair_digraph_cipher_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Square predictor state
   logic [4:0]  sq_cells [0:24];
   logic [4:0]  sq_place [0:25];
   logic [25:0] sq_used;
   int          sq_fill;
   logic        held_valid;
   logic [4:0]  held_letter;
   logic        mode_enc;

   cipher_char_type cipher_chars_q [$];
   int  mismatch_count = 0;
   bit  req_idle_on = 0;
   bit  rsp_idle_on = 0;
   bit  hold_req = 0;

   dir_row_type dir_rows [0:24] = '{
      '{KIND_MESSAGE, "A",   1'b0, 8'h00, 8'h00},
      '{KIND_END,     8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_CLEAR,   8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_SEAL,    8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "A",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "B",   1'b1, "B",   "C"},
      '{KIND_MESSAGE, "a",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "F",   1'b1, "F",   "L"},
      '{KIND_MESSAGE, "A",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "G",   1'b1, "B",   "F"},
      '{KIND_MESSAGE, "X",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "X",   1'b1, "Y",   "Y"},
      '{KIND_END,     8'h00, 1'b1, "Y",   "Y"},
      '{KIND_MESSAGE, "Z",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, 8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "z",   1'b1, "V",   "Y"},
      '{KIND_END,     8'h00, 1'b1, "V",   "Y"},
      '{KIND_END,     8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_KEYWORD, "Q",   1'b0, 8'h00, 8'h00},
      '{KIND_SEAL,    8'h00, 1'b0, 8'h00, 8'h00},
      '{KIND_UNUSED,  "A",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "j",   1'b0, 8'h00, 8'h00},
      '{KIND_MESSAGE, "i",   1'b1, "H",   "Y"},
      '{KIND_END,     8'h00, 1'b1, "H",   "Y"},
      '{KIND_KEYWORD, 8'hFF, 1'b0, 8'h00, 8'h00}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int letter_index(logic [7:0] b);
      int idx;
      if (b >= "A" && b <= "Z") begin
         idx = b - "A";
      end else if (b >= "a" && b <= "z") begin
         idx = b - "a";
      end else begin
         return -1;
      end
      if (idx == IDX_J) begin
         idx = IDX_I;
      end
      return idx;
   endfunction

   function automatic void square_clear();
      sq_used = '0;
      sq_used[IDX_J] = 1'b1;
      sq_fill = 0;
      held_valid = 1'b0;
      held_letter = '0;
   endfunction

   function automatic void square_place(int idx);
      if (idx < 0 || sq_used[idx] || sq_fill >= SQ_CELLS) begin
         return;
      end
      sq_cells[sq_fill] = 5'(idx);
      sq_place[idx] = 5'(sq_fill);
      sq_used[idx] = 1'b1;
      sq_fill++;
   endfunction

   function automatic void digraph_chars(logic [4:0] a, logic [4:0] b,
                                         output cipher_char_type o0,
                                         output cipher_char_type o1);
      int pa, pb, r1, c1, r2, c2, sh, ca, cb;
      pa = sq_place[a];
      pb = sq_place[b];
      r1 = pa / SQ_SIDE;
      c1 = pa % SQ_SIDE;
      r2 = pb / SQ_SIDE;
      c2 = pb % SQ_SIDE;
      sh = mode_enc ? 1 : 4;
      if (r1 == r2) begin
         ca = r1 * SQ_SIDE + (c1 + sh) % SQ_SIDE;
         cb = r2 * SQ_SIDE + (c2 + sh) % SQ_SIDE;
      end else if (c1 == c2) begin
         ca = ((r1 + sh) % SQ_SIDE) * SQ_SIDE + c1;
         cb = ((r2 + sh) % SQ_SIDE) * SQ_SIDE + c2;
      end else begin
         ca = r1 * SQ_SIDE + c2;
         cb = r2 * SQ_SIDE + c1;
      end
      o0.ch = 8'(ASCII_A) + 8'(sq_cells[ca]);
      o0.last = 1'b0;
      o1.ch = 8'(ASCII_A) + 8'(sq_cells[cb]);
      o1.last = 1'b1;
   endfunction

   // Advance the square model by one item; return the number of result letters.
   function automatic int playfair_step(logic [2:0] kind, logic [7:0] raw,
                                        output cipher_char_type o0,
                                        output cipher_char_type o1);
      int idx;
      o0 = '0;
      o1 = '0;
      case (kind)
         KIND_CLEAR: begin
            square_clear();
         end
         KIND_KEYWORD: begin
            square_place(letter_index(raw));
         end
         KIND_SEAL: begin
            for (int i = 0; i < ALPHA; i++) begin
               square_place(i);
            end
         end
         KIND_MESSAGE: begin
            idx = letter_index(raw);
            if (sq_fill < SQ_CELLS || idx < 0) begin
               return 0;
            end
            if (!held_valid) begin
               held_letter = 5'(idx);
               held_valid = 1'b1;
               return 0;
            end
            if (5'(idx) == held_letter) begin
               digraph_chars(held_letter, IDX_X, o0, o1);
               return 2;
            end
            digraph_chars(held_letter, 5'(idx), o0, o1);
            held_valid = 1'b0;
            held_letter = '0;
            return 2;
         end
         KIND_END: begin
            if (sq_fill < SQ_CELLS || !held_valid) begin
               return 0;
            end
            digraph_chars(held_letter, IDX_X, o0, o1);
            held_valid = 1'b0;
            held_letter = '0;
            return 2;
         end
         default: begin
         end
      endcase
      return 0;
   endfunction

   function automatic logic [7:0] text_byte(logic [7:0] prev);
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         b = 8'(65 + $urandom_range(0, 25));
         b[5] = 1'($urandom_range(0, 1));
      end else if (r < 70) begin
         b = $urandom_range(0, 1) ? "j" : "J";
      end else if (r < 85) begin
         b = prev;
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   function automatic int sender_gap();
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 12);
      end
      return 0;
   endfunction

   task automatic note_mismatch(string what, logic [7:0] exp_v, logic [7:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
      end
   endtask

   task automatic send_item(logic [2:0] kind, logic [7:0] letter, int gap,
                            bit typed, logic [7:0] c0, logic [7:0] c1);
      cipher_char_type p0, p1;
      int n;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= letter;
      do begin
         @(posedge clock);
      end while (!req_tready);
      n = playfair_step(kind, letter, p0, p1);
      if (typed) begin
         cipher_chars_q.push_back('{c0, 1'b0});
         cipher_chars_q.push_back('{c1, 1'b1});
      end else if (n == 2) begin
         cipher_chars_q.push_back(p0);
         cipher_chars_q.push_back(p1);
      end
      @(negedge clock);
   endtask

   // Hold the sender until every result has arrived and the block has settled.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (cipher_chars_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (addr == CSR_ADDR_W'({REG_ENCRYPT_MODE, 2'b00})) begin
         mode_enc = value[0];
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Result receiver: random back-pressure and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
            rsp_tready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cipher_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_chars_q.size() == 0) begin
            note_mismatch("unexpected result", 8'h00, rsp_tdata);
         end else begin
            want = cipher_chars_q.pop_front();
            if (rsp_tdata != want.ch) begin
               note_mismatch("out_letter", want.ch, rsp_tdata);
            end
            if (rsp_tlast != want.last) begin
               note_mismatch("last", 8'(want.last), 8'(rsp_tlast));
            end
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_psel && csr_penable)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_item_type stim_q [$];
      logic [7:0] prev;
      logic [2:0] rand_kind;
      int len;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int i = 0; i < SQ_CELLS; i++) begin
         sq_cells[i] = '0;
      end
      for (int i = 0; i < ALPHA; i++) begin
         sq_place[i] = '0;
      end
      square_clear();
      mode_enc = 1'b1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_idle_on = 1;
      rsp_idle_on = 1;
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].kind, dir_rows[i].letter, sender_gap(),
                   dir_rows[i].typed, dir_rows[i].c0, dir_rows[i].c1);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         csr_write(CSR_ADDR_W'({REG_ENCRYPT_MODE, 2'b00}),
                   (phase == 0) ? 32'd0 : (phase == 1) ? 32'd1 : 32'($urandom_range(0, 1)));
         req_idle_on = (phase != PHASES - 1) && (phase % 3 != 2);
         rsp_idle_on = (phase != PHASES - 1) && (phase % 3 != 1);

         stim_q.delete();
         prev = "A";
         while (stim_q.size() < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               stim_q.push_back('{KIND_CLEAR, 8'($urandom_range(0, 255))});
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
               repeat (len) begin
                  prev = text_byte(prev);
                  stim_q.push_back('{KIND_KEYWORD, prev});
               end
               if ($urandom_range(0, 9) != 0) begin
                  stim_q.push_back('{KIND_SEAL, 8'($urandom_range(0, 255))});
               end
               len = $urandom_range(1, 30);
               repeat (len) begin
                  prev = text_byte(prev);
                  stim_q.push_back('{KIND_MESSAGE, prev});
               end
               if ($urandom_range(0, 4) != 0) begin
                  stim_q.push_back('{KIND_END, 8'($urandom_range(0, 255))});
               end
            end else begin
               len = $urandom_range(1, 10);
               repeat (len) begin
                  rand_kind = 3'($urandom_range(0, 7));
                  stim_q.push_back('{rand_kind, 8'($urandom_range(0, 255))});
               end
            end
         end

         if (phase == 1) begin
            hold_req = 1;
         end
         foreach (stim_q[i]) begin
            send_item(stim_q[i].kind, stim_q[i].letter, sender_gap(), 1'b0, 8'h00, 8'h00);
         end
      end

      drain_results();
      if (cipher_chars_q.size() != 0) begin
         note_mismatch("missing results", 8'(cipher_chars_q.size()), 8'h00);
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
